FILE: rtl/core/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg: shared types and helpers for the double index sort
// Request/result structs, insertion cell record, key ordering function.
// ----------------------------------------------------------------------------
`default_nettype none
package dis_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int POS_W         = 12;   // holds positions up to 4095
    localparam int ORD_W         = 65;   // NaN class bit + 64-bit order image

    typedef struct packed {
        logic [63:0] key_bits;
        logic        is_final_key;
    } t_in;

    typedef struct packed {
        logic [5:0] sorted_position;
        logic       is_final_result;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic [ORD_W-1:0] ord;
        logic [POS_W-1:0] pos;
    } t_cell;

    typedef struct packed {
        logic  load;      // insert new_cell into the chain
        logic  shift;     // move every cell one place toward cell 0
        t_cell new_cell;
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // Unsigned image whose order matches IEEE order; all NaNs collapse to one top value.
    function automatic logic [ORD_W-1:0] order_key(input logic [63:0] b);
        logic        is_nan;
        logic [63:0] m;
        is_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        m      = (b[62:0] == 63'd0) ? 64'd0 : b;
        if (is_nan) begin
            order_key = {1'b1, 64'd0};
        end else if (m[63]) begin
            order_key = {1'b0, ~m};
        end else begin
            order_key = {1'b0, m | 64'h8000_0000_0000_0000};
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dis_cell.sv
// ----------------------------------------------------------------------------
// dis_cell: one insertion cell of the sort chain
// Holds one key image and position; takes new key, left neighbor or right one.
// ----------------------------------------------------------------------------
`default_nettype none
module dis_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dis_pkg::t_cell_ctl i_ctl,
    input  wire dis_pkg::t_cell    i_left,
    input  wire logic              i_left_gt,
    input  wire dis_pkg::t_cell    i_right,
    output dis_pkg::t_cell         o_cell,
    output logic                   o_gt
);
    dis_pkg::t_cell r_cell, n_cell;

    // empty cells count as above every key; equal keys stay ahead (stable)
    assign o_gt = !r_cell.valid || (r_cell.ord > i_ctl.new_cell.ord);

    always_comb begin
        n_cell = r_cell;
        if (i_ctl.shift) begin
            n_cell = i_right;
        end else if (i_ctl.load && o_gt) begin
            n_cell = i_left_gt ? i_left : i_ctl.new_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.ord <= n_cell.ord;
        r_cell.pos <= n_cell.pos;
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

FILE: rtl/core/double_index_sort.sv
// ----------------------------------------------------------------------------
// double_index_sort: stable argsort of IEEE-754 double keys
// Insertion cell chain; loads keys, then streams sorted load positions.
// ----------------------------------------------------------------------------
// Keys enter one request per cycle; each is inserted in the same cycle into a
// chain of MAX_ITEMS cells by a broadcast compare, so loading runs at one key
// per cycle. The request with is_final_key closes the set; the block then
// streams one sorted position per cycle while i_ready is high, out of cell 0
// as the chain shifts toward it, and no request is taken until the set has
// drained. Ordering is IEEE: -0 equals +0, NaNs sort last and tie; ties keep
// load order. Keys past MAX_ITEMS are dropped; positions are reported in
// 6 bits.
`default_nettype none
module double_index_sort #(
    parameter int MAX_ITEMS = dis_pkg::MAX_ITEMS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire dis_pkg::t_in i_req,
    output logic              o_valid,
    input  wire logic         i_ready,
    output dis_pkg::t_out     o_rsp
);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    dis_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    dis_pkg::t_cell_ctl ctl;
    dis_pkg::t_cell     cells [MAX_ITEMS];
    logic               gts   [MAX_ITEMS];
    logic               in_acc, out_acc, full;

    assign o_ready = (r_state == dis_pkg::ST_LOAD);
    assign o_valid = (r_state == dis_pkg::ST_EMIT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign full    = (r_count == CNT_W'(MAX_ITEMS));

    always_comb begin
        ctl.load           = in_acc && !full;
        ctl.shift          = out_acc;
        ctl.new_cell.valid = 1'b1;
        ctl.new_cell.ord   = dis_pkg::order_key(i_req.key_bits);
        ctl.new_cell.pos   = dis_pkg::POS_W'(r_count);
    end

    // chain of cells; cell 0 is the head that feeds the output
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        dis_pkg::t_cell left_c, right_c;
        logic           left_gt;
        if (g == 0) begin : g_head
            assign left_c  = '0;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left_c  = cells[g-1];
            assign left_gt = gts[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_c = '0;
        end else begin : g_body
            assign right_c = cells[g+1];
        end
        dis_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_left   (left_c),
            .i_left_gt(left_gt),
            .i_right  (right_c),
            .o_cell   (cells[g]),
            .o_gt     (gts[g])
        );
    end

    // count holds keys loaded, then results still to send
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            dis_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (!full) n_count = r_count + CNT_W'(1);
                    if (i_req.is_final_key) n_state = dis_pkg::ST_EMIT;
                end
            end
            dis_pkg::ST_EMIT: begin
                if (out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) n_state = dis_pkg::ST_LOAD;
                end
            end
            default: n_state = dis_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dis_pkg::ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_rsp.sorted_position = cells[0].pos[5:0];
    assign o_rsp.is_final_result = (r_count == CNT_W'(1));

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> cells[0].valid)
        else $error("head cell empty while sending");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("count beyond capacity");
    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0))
        else $error("sending with nothing left");
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_rsp.is_final_result) |=> !cells[0].valid)
        else $error("chain not empty after last result");
endmodule
`default_nettype wire
